// ===== rtl/quaternion_to_pitch_yaw_core_defines.svh =====
// Assertion helpers for the quaternion to pitch/yaw core.
`ifndef QUATERNION_TO_PITCH_YAW_CORE_DEFINES_SVH
`define QUATERNION_TO_PITCH_YAW_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define QPY_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define QPY_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/qpy_pkg.sv =====
package qpy_pkg;

  localparam int QW        = 32;  // Q30 component width
  localparam int ROOT_BITS = 31;  // q0 <= 2^30
  localparam int ARGW      = 61;  // Q60 argument <= 2^60
  localparam int PW        = 62;  // signed Q60 products
  localparam int TW        = 64;  // atan2 operands
  localparam int NORM_STAGES  = 6;
  localparam int CORDIC_STEPS = 22;
  localparam int CW        = 44;  // CORDIC x/y
  localparam int ZW        = 25;  // angle, Q16 degrees
  localparam int LANE_LAT  = NORM_STAGES + CORDIC_STEPS + 1;

  localparam logic signed [QW-1:0] Q30_ONE = 32'sh4000_0000;
  localparam logic [ARGW-1:0] Q60_ONE = 61'h1000_0000_0000_0000;
  localparam logic signed [ZW-1:0] DEG90_Q16  = 25'sd5898240;
  localparam logic signed [ZW-1:0] DEG180_Q16 = 25'sd11796480;

  typedef struct packed {
    logic [TW-1:0] ax;
    logic [TW-1:0] ay;
    logic          x_neg;
    logic          y_neg;
  } qpy_lane_in_t;

  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic zero;
  } qpy_quad_t;

  // atan(2^-i) in degrees, Q16
  function automatic logic signed [ZW-1:0] atan_q16(input int idx);
    logic signed [ZW-1:0] r;
    case (idx)
      0:  r = 25'sd2949120;
      1:  r = 25'sd1740967;
      2:  r = 25'sd919879;
      3:  r = 25'sd466945;
      4:  r = 25'sd234379;
      5:  r = 25'sd117304;
      6:  r = 25'sd58666;
      7:  r = 25'sd29335;
      8:  r = 25'sd14668;
      9:  r = 25'sd7334;
      10: r = 25'sd3667;
      11: r = 25'sd1833;
      12: r = 25'sd917;
      13: r = 25'sd458;
      14: r = 25'sd229;
      15: r = 25'sd115;
      16: r = 25'sd57;
      17: r = 25'sd29;
      18: r = 25'sd14;
      19: r = 25'sd7;
      20: r = 25'sd4;
      21: r = 25'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/quaternion_to_pitch_yaw_core.sv =====
// Quaternion to pitch/yaw converter. Each input beat carries q1..q3 in signed
// Q30 plus two gyro counts; q0 is rebuilt as the floor square root of one
// minus the vector norm (zero when the norm exceeds one), and pitch and yaw
// come out as signed Q16 degrees within +-180, with the gyro counts copied
// alongside. A beat with quat_valid low is consumed and gives no result.
// Throughput is one beat per clock unless the output stalls; the pipeline
// has 31 one-bit square-root stages and 22 CORDIC vectoring stages per angle.
// The whole pipeline holds while a finished result is stalled at the output.
`include "quaternion_to_pitch_yaw_core_defines.svh"
module quaternion_to_pitch_yaw_core
  import qpy_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 quat_valid,
  input  logic signed [31:0]   quat_x,
  input  logic signed [31:0]   quat_y,
  input  logic signed [31:0]   quat_z,
  input  logic signed [15:0]   roll_axis_rate,
  input  logic signed [15:0]   vertical_axis_rate,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [24:0]   pitch_deg,
  output logic signed [24:0]   yaw_deg,
  output logic signed [15:0]   pitch_rate_out,
  output logic signed [15:0]   yaw_rate_out
);

  // Stage map: 1 saturate, 2 multiply, 3 root argument and t1/t4,
  // 4..34 square root, 35 q0 products, 36 t0/t3, 37 magnitudes,
  // then the two atan2 lanes, whose last register is the output.
  localparam int SQ_STAGES = ROOT_BITS;
  localparam int LAT = 6 + SQ_STAGES + LANE_LAT;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // Valid bits and gyro counts ride along the full depth.
  logic [LAT-1:0] vld;
  logic [31:0]    rate_dly [0:LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid && quat_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rate_dly[0] <= {roll_axis_rate, vertical_axis_rate};
      for (int k = 1; k < LAT; k++) rate_dly[k] <= rate_dly[k-1];
    end
  end

  // Stage 1: saturate components to +-1.0
  function automatic logic signed [QW-1:0] sat_q30(input logic signed [QW-1:0] v);
    logic signed [QW-1:0] r;
    r = v;
    if (v > Q30_ONE) r = Q30_ONE;
    if (v < -Q30_ONE) r = -Q30_ONE;
    return r;
  endfunction

  logic signed [QW-1:0] q1_a, q2_a, q3_a;
  always_ff @(posedge clk) begin
    if (en) begin
      q1_a <= sat_q30(quat_x);
      q2_a <= sat_q30(quat_y);
      q3_a <= sat_q30(quat_z);
    end
  end

  // Stage 2: squares and cross products, Q60
  logic [ARGW-1:0]      s11_b, s22_b, s33_b;
  logic signed [PW-1:0] p12_b, p23_b;
  logic signed [QW-1:0] q1_b, q3_b;
  logic signed [63:0]   m11, m22, m33, m12, m23;

  always_comb begin
    m11 = q1_a * q1_a;
    m22 = q2_a * q2_a;
    m33 = q3_a * q3_a;
    m12 = q1_a * q2_a;
    m23 = q2_a * q3_a;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s11_b <= m11[ARGW-1:0];
      s22_b <= m22[ARGW-1:0];
      s33_b <= m33[ARGW-1:0];
      p12_b <= m12[PW-1:0];
      p23_b <= m23[PW-1:0];
      q1_b  <= q1_a;
      q3_b  <= q3_a;
    end
  end

  // Stage 3: root argument (clamped at zero) and the cosine-side terms
  typedef struct packed {
    logic signed [QW-1:0] q1;
    logic signed [QW-1:0] q3;
    logic signed [PW-1:0] p12;
    logic signed [PW-1:0] p23;
    logic signed [TW-1:0] t1;
    logic signed [TW-1:0] t4;
  } side_t;

  logic [ARGW+1:0]      sum3;
  logic [ARGW:0]        sum12, sum23;
  logic [ARGW-1:0]      arg_next;
  logic signed [TW-1:0] t1_next, t4_next;

  always_comb begin
    sum3  = {2'b00, s11_b} + {2'b00, s22_b} + {2'b00, s33_b};
    sum12 = {1'b0, s11_b} + {1'b0, s22_b};
    sum23 = {1'b0, s22_b} + {1'b0, s33_b};
    if (sum3 > {2'b00, Q60_ONE}) begin
      arg_next = '0;
    end else begin
      arg_next = Q60_ONE - sum3[ARGW-1:0];
    end
    t1_next = $signed({3'b000, Q60_ONE}) - $signed({1'b0, sum12, 1'b0});
    t4_next = $signed({3'b000, Q60_ONE}) - $signed({1'b0, sum23, 1'b0});
  end

  logic [ARGW-1:0]      sq_rem  [0:SQ_STAGES];
  logic [ROOT_BITS-1:0] sq_root [0:SQ_STAGES];
  side_t                sq_side [0:SQ_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0]  <= arg_next;
      sq_root[0] <= '0;
      sq_side[0] <= '{q1: q1_b, q3: q3_b, p12: p12_b, p23: p23_b,
                      t1: t1_next, t4: t4_next};
    end
  end

  // Square root, one result bit per stage, MSB first
  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
    localparam int B = SQ_STAGES - 1 - j;
    logic [63:0] trial, rem_w;
    always_comb begin
      rem_w = {{(64-ARGW){1'b0}}, sq_rem[j]};
      trial = ({{(64-ROOT_BITS){1'b0}}, sq_root[j]} << (B + 1)) + (64'd1 << (2 * B));
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_side[j+1] <= sq_side[j];
        if (rem_w >= trial) begin
          sq_rem[j+1]  <= sq_rem[j] - trial[ARGW-1:0];
          sq_root[j+1] <= sq_root[j] | (ROOT_BITS'(1) << B);
        end else begin
          sq_rem[j+1]  <= sq_rem[j];
          sq_root[j+1] <= sq_root[j];
        end
      end
    end
  end

  // Stage 35: q0 products
  side_t                sd_c;
  logic signed [PW-1:0] m01_c, m03_c;
  logic signed [63:0]   q0q1, q0q3;
  logic signed [QW-1:0] q0_s;

  assign q0_s = $signed({1'b0, sq_root[SQ_STAGES]});

  always_comb begin
    q0q1 = q0_s * sq_side[SQ_STAGES].q1;
    q0q3 = q0_s * sq_side[SQ_STAGES].q3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_c  <= sq_side[SQ_STAGES];
      m01_c <= q0q1[PW-1:0];
      m03_c <= q0q3[PW-1:0];
    end
  end

  // Stage 36: sine-side terms
  logic signed [TW-1:0] t0_d, t1_d, t3_d, t4_d;
  logic signed [TW-1:0] sum01, sum03;

  always_comb begin
    sum01 = TW'(m01_c) + TW'(sd_c.p23);
    sum03 = TW'(m03_c) + TW'(sd_c.p12);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_d <= sum01 <<< 1;
      t3_d <= sum03 <<< 1;
      t1_d <= sd_c.t1;
      t4_d <= sd_c.t4;
    end
  end

  // Stage 37: magnitudes and signs for the atan2 lanes
  function automatic logic [TW-1:0] mag(input logic signed [TW-1:0] v);
    return v[TW-1] ? TW'(-v) : TW'(v);
  endfunction

  qpy_lane_in_t pitch_in, yaw_in;

  always_ff @(posedge clk) begin
    if (en) begin
      pitch_in <= '{ax: mag(t1_d), ay: mag(t0_d), x_neg: t1_d[TW-1], y_neg: t0_d[TW-1]};
      yaw_in   <= '{ax: mag(t4_d), ay: mag(t3_d), x_neg: t4_d[TW-1], y_neg: t3_d[TW-1]};
    end
  end

  qpy_atan2_lane u_pitch (
    .clk (clk),
    .en  (en),
    .lin (pitch_in),
    .ang (pitch_deg)
  );

  qpy_atan2_lane u_yaw (
    .clk (clk),
    .en  (en),
    .lin (yaw_in),
    .ang (yaw_deg)
  );

  assign out_valid      = vld[LAT-1];
  assign pitch_rate_out = rate_dly[LAT-1][31:16];
  assign yaw_rate_out   = rate_dly[LAT-1][15:0];

  `QPY_ASSERT_IMP(a_pitch_range, out_valid, (pitch_deg <= DEG180_Q16) && (pitch_deg >= -DEG180_Q16), "pitch outside +-180 deg")
  `QPY_ASSERT_IMP(a_yaw_range, out_valid, (yaw_deg <= DEG180_Q16) && (yaw_deg >= -DEG180_Q16), "yaw outside +-180 deg")
  `QPY_ASSERT_NXT(a_pipe_hold, out_valid && out_stall, $stable(vld), "pipeline moved while output stalled")

endmodule

// ===== rtl/qpy_atan2_lane.sv =====
module qpy_atan2_lane
  import qpy_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  qpy_lane_in_t         lin,
  output logic signed [ZW-1:0] ang
);

  logic [TW-1:0] nax [0:NORM_STAGES];
  logic [TW-1:0] nay [0:NORM_STAGES];
  qpy_quad_t     nf  [0:NORM_STAGES];

  assign nax[0] = lin.ax;
  assign nay[0] = lin.ay;
  assign nf[0]  = '{x_neg: lin.x_neg, y_neg: lin.y_neg, zero: 1'b0};

  // Left-normalize so the larger magnitude has its MSB at bit 63.
  for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
    localparam int SH = 32 >> k;
    logic [TW-1:0] m;
    assign m = nax[k] | nay[k];
    always_ff @(posedge clk) begin
      if (en) begin
        nf[k+1] <= nf[k];
        if (m[TW-1 -: SH] == '0) begin
          nax[k+1] <= nax[k] << SH;
          nay[k+1] <= nay[k] << SH;
        end else begin
          nax[k+1] <= nax[k];
          nay[k+1] <= nay[k];
        end
      end
    end
  end

  logic signed [CW-1:0] cx [0:CORDIC_STEPS];
  logic signed [CW-1:0] cy [0:CORDIC_STEPS];
  logic signed [ZW-1:0] cz [0:CORDIC_STEPS];
  qpy_quad_t            cf [0:CORDIC_STEPS];

  // MSB at bit 40 after dropping 23 bits
  assign cx[0] = $signed({3'b000, nax[NORM_STAGES][TW-1:23]});
  assign cy[0] = $signed({3'b000, nay[NORM_STAGES][TW-1:23]});
  assign cz[0] = '0;
  assign cf[0] = '{x_neg: nf[NORM_STAGES].x_neg, y_neg: nf[NORM_STAGES].y_neg,
                   zero: (nax[NORM_STAGES] == '0) && (nay[NORM_STAGES] == '0)};

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] ATAN = atan_q16(i);
    always_ff @(posedge clk) begin
      if (en) begin
        cf[i+1] <= cf[i];
        if (cy[i] > 0) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ATAN;
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ATAN;
        end
      end
    end
  end

  logic signed [ZW-1:0] zc, zq, ang_next;
  qpy_quad_t            ff;

  always_comb begin
    ff = cf[CORDIC_STEPS];
    zc = cz[CORDIC_STEPS];
    if (zc < 0) zc = '0;
    if (zc > DEG90_Q16) zc = DEG90_Q16;
    zq = ff.x_neg ? (DEG180_Q16 - zc) : zc;
    if (ff.zero) begin
      ang_next = '0;
    end else if (ff.y_neg) begin
      ang_next = -zq;
    end else begin
      ang_next = zq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) ang <= ang_next;
  end

endmodule
